// File: src/gmht_pkg.sv
`timescale 1ns / 1ps
package gmht_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX,
    ST_MAPY,
    ST_POS,
    ST_DIST,
    ST_CORDIC,
    ST_ROUND,
    ST_SMOOTH,
    ST_DONE
  } state_t;

  localparam logic [2:0] REG_LON_MIN      = 3'd0;
  localparam logic [2:0] REG_LON_MAX      = 3'd1;
  localparam logic [2:0] REG_LAT_MIN      = 3'd2;
  localparam logic [2:0] REG_LAT_MAX      = 3'd3;
  localparam logic [2:0] REG_SCENE_LEFT   = 3'd4;
  localparam logic [2:0] REG_SCENE_BOTTOM = 3'd5;
  localparam logic [2:0] REG_SCENE_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SCENE_HEIGHT = 3'd7;

  // axis mapping outcome
  localparam logic [1:0] AXIS_ZERO = 2'd0;
  localparam logic [1:0] AXIS_FULL = 2'd1;
  localparam logic [1:0] AXIS_DIV  = 2'd2;

  localparam int CordicSteps = 18;
  localparam int FullTurn    = 36000;
  localparam int HalfTurn    = 18000;

  function automatic logic [24:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 25'd18432000;
      5'd1:  atan_lut = 25'd10881045;
      5'd2:  atan_lut = 25'd5749245;
      5'd3:  atan_lut = 25'd2918407;
      5'd4:  atan_lut = 25'd1464867;
      5'd5:  atan_lut = 25'd733147;
      5'd6:  atan_lut = 25'd366663;
      5'd7:  atan_lut = 25'd183343;
      5'd8:  atan_lut = 25'd91673;
      5'd9:  atan_lut = 25'd45837;
      5'd10: atan_lut = 25'd22918;
      5'd11: atan_lut = 25'd11459;
      5'd12: atan_lut = 25'd5730;
      5'd13: atan_lut = 25'd2865;
      5'd14: atan_lut = 25'd1432;
      5'd15: atan_lut = 25'd716;
      5'd16: atan_lut = 25'd358;
      5'd17: atan_lut = 25'd179;
      default: atan_lut = 25'd0;
    endcase
  endfunction

endpackage

// File: src/gps_map_heading_tracker_core.sv
`timescale 1ns / 1ps
// From request accept to result valid: two bit-serial divides (a load step and 20 quotient
// steps each), a position and a distance state, then, only when a course is estimated,
// 18 CORDIC steps, a round and a smooth state.
// Only one request is in flight at a time; a result still waiting on out_tready holds
// the next request back.
// Reset (rst_n low, synchronous) restores map registers to defaults and clears track state.
module gps_map_heading_tracker_core #(
  parameter int ROUTE_LIMIT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // latitude_e7[30:0], longitude_e7[62:31], heading_cdeg[78:63], heading_valid[79]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pos_x[21:0], pos_y[43:22], shown_heading[59:44], heading_shown[60],
  // route_append[61], route_points[73:62], zero fill[79:74]
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CntW = $clog2(ROUTE_LIMIT + 1);

  // map registers
  logic signed [31:0] lon_min_r, lon_max_r;
  logic signed [30:0] lat_min_r, lat_max_r;
  logic signed [20:0] scene_left_r, scene_bottom_r;
  logic [19:0] scene_width_r, scene_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_min_r <= '0; lon_max_r <= 32'sd10000000;
      lat_min_r <= '0; lat_max_r <= 31'sd10000000;
      scene_left_r <= '0; scene_bottom_r <= 21'sd16384;
      scene_width_r <= 20'd16384; scene_height_r <= 20'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        gmht_pkg::REG_LON_MIN:      lon_min_r <= cfg_wdata;
        gmht_pkg::REG_LON_MAX:      lon_max_r <= cfg_wdata;
        gmht_pkg::REG_LAT_MIN:      lat_min_r <= cfg_wdata[30:0];
        gmht_pkg::REG_LAT_MAX:      lat_max_r <= cfg_wdata[30:0];
        gmht_pkg::REG_SCENE_LEFT:   scene_left_r <= cfg_wdata[20:0];
        gmht_pkg::REG_SCENE_BOTTOM: scene_bottom_r <= cfg_wdata[20:0];
        gmht_pkg::REG_SCENE_WIDTH:  scene_width_r <= cfg_wdata[19:0];
        gmht_pkg::REG_SCENE_HEIGHT: scene_height_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  gmht_pkg::state_t state_r, state_nxt;

  // request latch
  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;
  logic [15:0] hdg_r;
  logic hdg_ok_r;

  // divide unit: numerator and span magnitudes, running remainder, quotient
  logic [33:0] num_r, den_r;
  logic [33:0] rem_r;
  logic [19:0] quo_r;
  logic [19:0] size_r;
  logic [1:0]  mode_r;
  logic        div_run_r;
  logic [4:0]  cnt_r;
  logic [19:0] offx_r;

  logic signed [21:0] x_r, y_r;

  // track state
  logic signed [21:0] prev_x_r, prev_y_r, tail_x_r, tail_y_r;
  logic have_prev_r, have_smooth_r;
  logic [15:0] smooth_r;
  logic [CntW-1:0] count_r;

  // cordic
  logic signed [40:0] ca_r, cb_r;
  logic signed [27:0] cz_r;
  logic append_r;

  logic [79:0] out_data_r;
  logic out_valid_r;

  // axis setup: span sign handling and clamp decisions
  function automatic logic [1:0] axis_mode(input logic signed [33:0] n,
                                           input logic signed [33:0] d);
    logic signed [33:0] nn, dd;
    begin
      nn = n; dd = d;
      if (dd < 0) begin nn = -nn; dd = -dd; end
      if (dd == 0 || nn <= 0) axis_mode = gmht_pkg::AXIS_ZERO;
      else if (nn >= dd) axis_mode = gmht_pkg::AXIS_FULL;
      else axis_mode = gmht_pkg::AXIS_DIV;
    end
  endfunction

  function automatic logic [33:0] absn(input logic signed [33:0] n,
                                       input logic signed [33:0] d);
    absn = (d < 0) ? -n : n;
  endfunction

  logic signed [33:0] nx, dx_s, ny, dy_s;
  assign nx   = 34'(lon_r) - 34'(lon_min_r);
  assign dx_s = 34'(lon_max_r) - 34'(lon_min_r);
  assign ny   = 34'(lat_r) - 34'(lat_min_r);
  assign dy_s = 34'(lat_max_r) - 34'(lat_min_r);

  // division step, size fed MSB first: acc = 2*rem + num*bit, quotient digit 0..2
  logic [35:0] acc, den1, den2;
  logic [33:0] rem_nxt;
  logic [19:0] quo_nxt;
  logic [19:0] off_nxt;
  logic [19:0] size_sel;
  assign den1 = 36'(den_r);
  assign den2 = {1'b0, den_r, 1'b0};
  assign acc  = {1'b0, rem_r, 1'b0} + (size_r[19] ? 36'(num_r) : 36'd0);
  assign size_sel = (state_r == gmht_pkg::ST_MAPX) ? scene_width_r : scene_height_r;

  always_comb begin
    if (acc >= den2) begin
      rem_nxt = 34'(acc - den2);
      quo_nxt = {quo_r[18:0], 1'b0} + 20'd2;
    end else if (acc >= den1) begin
      rem_nxt = 34'(acc - den1);
      quo_nxt = {quo_r[18:0], 1'b1};
    end else begin
      rem_nxt = acc[33:0];
      quo_nxt = {quo_r[18:0], 1'b0};
    end
  end

  always_comb begin
    case (mode_r)
      gmht_pkg::AXIS_ZERO: off_nxt = '0;
      gmht_pkg::AXIS_FULL: off_nxt = size_sel;
      default:             off_nxt = quo_nxt;
    endcase
  end

  // distance squares from magnitudes
  logic signed [22:0] ddx, ddy, rdx, rdy;
  assign ddx = 23'(x_r) - 23'(prev_x_r);
  assign ddy = 23'(y_r) - 23'(prev_y_r);
  assign rdx = 23'(x_r) - 23'(tail_x_r);
  assign rdy = 23'(y_r) - 23'(tail_y_r);
  logic [21:0] adx, ady, arx, ary;
  assign adx = ddx[22] ? 22'(-ddx) : ddx[21:0];
  assign ady = ddy[22] ? 22'(-ddy) : ddy[21:0];
  assign arx = rdx[22] ? 22'(-rdx) : rdx[21:0];
  assign ary = rdy[22] ? 22'(-rdy) : rdy[21:0];
  logic [43:0] adx_sq, ady_sq, arx_sq, ary_sq;
  assign adx_sq = adx * adx;
  assign ady_sq = ady * ady;
  assign arx_sq = arx * arx;
  assign ary_sq = ary * ary;
  logic [44:0] dsq, rsq;
  assign dsq = 45'(adx_sq) + 45'(ady_sq);
  assign rsq = 45'(arx_sq) + 45'(ary_sq);

  logic est_w;
  assign est_w = have_prev_r && (dsq >= 45'd1024);

  // cordic step
  logic signed [40:0] as_w, bs_w;
  logic [4:0] ci;
  assign ci   = cnt_r;
  assign as_w = ca_r >>> ci;
  assign bs_w = cb_r >>> ci;

  // round to centidegrees and wrap once
  logic signed [28:0] zr;
  logic signed [16:0] cr, cw;
  assign zr = (29'(cz_r) + 29'sd2048) >>> 12;
  assign cr = zr[16:0];
  always_comb begin
    cw = cr;
    if (cr < 0) cw = cr + 17'(gmht_pkg::FullTurn);
    else if (cr >= 17'(gmht_pkg::FullTurn)) cw = cr - 17'(gmht_pkg::FullTurn);
  end

  // smoothing: wrapped delta scaled by 22938/65536
  logic signed [17:0] sm_w, sd0, sd, ssum, snew;
  logic signed [35:0] sprod;
  assign sm_w = 18'($signed({1'b0, smooth_r}));
  assign sd0  = 18'(cz_r) - sm_w;
  always_comb begin
    sd = sd0;
    if (sd0 > 18'(gmht_pkg::HalfTurn)) sd = sd0 - 18'(gmht_pkg::FullTurn);
    else if (sd0 < -18'(gmht_pkg::HalfTurn)) sd = sd0 + 18'(gmht_pkg::FullTurn);
  end
  assign sprod = sd * 36'sd22938;
  assign ssum  = sm_w + 18'(sprod >>> 16);
  always_comb begin
    snew = ssum;
    if (ssum < 0) snew = ssum + 18'(gmht_pkg::FullTurn);
    else if (ssum >= 18'(gmht_pkg::FullTurn)) snew = ssum - 18'(gmht_pkg::FullTurn);
  end

  logic [15:0] hdg_fix;
  assign hdg_fix = (hdg_r >= 16'd36000) ? hdg_r - 16'd36000 : hdg_r;

  // result fields
  logic [CntW-1:0] count_nxt;
  logic sok_w;
  logic [15:0] sh_w;
  always_comb begin
    count_nxt = count_r;
    if (append_r && count_r < CntW'(ROUTE_LIMIT)) count_nxt = count_r + CntW'(1);
    sok_w = hdg_ok_r;
    sh_w = hdg_ok_r ? hdg_fix : 16'd0;
    if (have_prev_r && have_smooth_r) begin
      sok_w = 1'b1;
      sh_w = smooth_r;
    end
  end

  logic out_load;
  assign out_load = (state_r == gmht_pkg::ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gmht_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  assign in_tready = (state_r == gmht_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmht_pkg::ST_IDLE:   if (in_tvalid) state_nxt = gmht_pkg::ST_MAPX;
      gmht_pkg::ST_MAPX:   if (div_run_r && cnt_r == 5'd0) state_nxt = gmht_pkg::ST_MAPY;
      gmht_pkg::ST_MAPY:   if (div_run_r && cnt_r == 5'd0) state_nxt = gmht_pkg::ST_POS;
      gmht_pkg::ST_POS:    state_nxt = gmht_pkg::ST_DIST;
      gmht_pkg::ST_DIST:   state_nxt = est_w ? gmht_pkg::ST_CORDIC : gmht_pkg::ST_DONE;
      gmht_pkg::ST_CORDIC: if (cnt_r == 5'(gmht_pkg::CordicSteps - 1))
                             state_nxt = gmht_pkg::ST_ROUND;
      gmht_pkg::ST_ROUND:  state_nxt = gmht_pkg::ST_SMOOTH;
      gmht_pkg::ST_SMOOTH: state_nxt = gmht_pkg::ST_DONE;
      gmht_pkg::ST_DONE:   if (out_load) state_nxt = gmht_pkg::ST_IDLE;
      default:             state_nxt = gmht_pkg::ST_IDLE;
    endcase
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0; have_smooth_r <= 1'b0; smooth_r <= '0;
      prev_x_r <= '0; prev_y_r <= '0; tail_x_r <= '0; tail_y_r <= '0;
      count_r <= '0; cnt_r <= '0; div_run_r <= 1'b0;
    end else begin
      case (state_r)
        gmht_pkg::ST_IDLE: if (in_tvalid) begin
          lat_r <= in_tdata[30:0]; lon_r <= in_tdata[62:31];
          hdg_r <= in_tdata[78:63]; hdg_ok_r <= in_tdata[79];
        end
        gmht_pkg::ST_MAPX, gmht_pkg::ST_MAPY: begin
          if (!div_run_r) begin
            // load one axis
            div_run_r <= 1'b1;
            if (state_r == gmht_pkg::ST_MAPX) begin
              mode_r <= axis_mode(nx, dx_s);
              num_r <= absn(nx, dx_s);
              den_r <= absn(dx_s, dx_s);
              size_r <= scene_width_r;
            end else begin
              mode_r <= axis_mode(ny, dy_s);
              num_r <= absn(ny, dy_s);
              den_r <= absn(dy_s, dy_s);
              size_r <= scene_height_r;
            end
            rem_r <= '0; quo_r <= '0; cnt_r <= 5'd19;
          end else begin
            // advance one quotient digit
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            size_r <= {size_r[18:0], 1'b0};
            if (cnt_r == 5'd0) begin
              div_run_r <= 1'b0;
              if (state_r == gmht_pkg::ST_MAPX) offx_r <= off_nxt;
              else y_r <= 22'(scene_bottom_r) - 22'(off_nxt);
            end else cnt_r <= cnt_r - 5'd1;
          end
        end
        gmht_pkg::ST_POS: begin
          x_r <= 22'(scene_left_r) + 22'(offx_r);
        end
        gmht_pkg::ST_DIST: begin
          append_r <= (count_r == '0) || (rsq > 45'd4096);
          // vector (east=dx, north=-dy) scaled by 2^16, folded to north >= 0
          if (ddy > 0) begin
            ca_r <= 41'(ddy) <<< 16; cb_r <= -(41'(ddx) <<< 16);
            cz_r <= 28'(gmht_pkg::HalfTurn * 4096);
          end else begin
            ca_r <= -(41'(ddy) <<< 16); cb_r <= 41'(ddx) <<< 16;
            cz_r <= '0;
          end
          cnt_r <= 5'd0;
        end
        gmht_pkg::ST_CORDIC: begin
          if (cb_r > 0) begin
            ca_r <= ca_r + bs_w; cb_r <= cb_r - as_w;
            cz_r <= cz_r + 28'(gmht_pkg::atan_lut(ci));
          end else begin
            ca_r <= ca_r - bs_w; cb_r <= cb_r + as_w;
            cz_r <= cz_r - 28'(gmht_pkg::atan_lut(ci));
          end
          cnt_r <= cnt_r + 5'd1;
        end
        gmht_pkg::ST_ROUND: begin
          cz_r <= 28'(cw);
        end
        gmht_pkg::ST_SMOOTH: begin
          if (!have_smooth_r) smooth_r <= 16'(cz_r);
          else smooth_r <= 16'(snew);
          have_smooth_r <= 1'b1;
        end
        gmht_pkg::ST_DONE: if (out_load) begin
          count_r <= count_nxt;
          if (append_r) begin tail_x_r <= x_r; tail_y_r <= y_r; end
          prev_x_r <= x_r; prev_y_r <= y_r; have_prev_r <= 1'b1;
          out_data_r <= {6'd0, 12'(count_nxt), append_r, sok_w, sh_w, y_r, x_r};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
